FILE: design/indexed_insert_delete_array_macros.svh
// assertion helpers for the top design file indexed_insert_delete_array.sv
`ifndef INDEXED_INSERT_DELETE_ARRAY_MACROS_SVH
`define INDEXED_INSERT_DELETE_ARRAY_MACROS_SVH

// same-cycle implication, checked outside reset
`define IIDA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iida assertion failed");

// next-cycle implication, checked outside reset
`define IIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iida assertion failed");

`endif

FILE: design/iida_pkg.sv
package iida_pkg;

    localparam int CAPACITY   = 256;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // compare width wide enough for both the 8-bit index and the count
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    // read-back tree: groups of cells or-ed into one register each
    localparam int GRP_SIZE = 16;
    localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    typedef enum logic [2:0] {
        FN_APPEND    = 3'd0,
        FN_DROP_LAST = 3'd1,
        FN_INSERT    = 3'd2,
        FN_ERASE     = 3'd3,
        FN_OVERWRITE = 3'd4,
        FN_READ      = 3'd5,
        FN_READ_LAST = 3'd6,
        FN_CLEAR     = 3'd7
    } func_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_ERASE  = 2'd3
    } cmd_t;

    // broadcast to every cell
    typedef struct packed {
        cmd_t                  cmd;
        logic [IDX_W-1:0]      tgt;
        logic [IDX_W-1:0]      sel;
        logic [DATA_WIDTH-1:0] data;
    } cell_ctl_t;

    function automatic logic [DATA_WIDTH-1:0] to_elem(input logic [31:0] raw);
        logic signed [63:0] wide;
        wide = 64'(signed'(raw));
        return wide[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] from_elem(input logic [DATA_WIDTH-1:0] e);
        logic signed [63:0] wide;
        wide = 64'(signed'(e));
        return wide[31:0];
    endfunction

endpackage

FILE: design/iida_cell.sv
module iida_cell
    import iida_pkg::*;
(
    input  logic                  clk,
    input  logic [IDX_W-1:0]      pos,
    input  cell_ctl_t             ctl,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data_out,
    output logic [DATA_WIDTH-1:0] rd_out
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.cmd)
            CMD_HOLD:
            begin
                data_next = data_reg;
            end
            CMD_LOAD:
            begin
                if (pos == ctl.tgt)
                begin
                    data_next = ctl.data;
                end
            end
            CMD_INSERT:
            begin
                // cells above the slot take their left neighbor
                if (pos > ctl.tgt)
                begin
                    data_next = left_data;
                end
                else if (pos == ctl.tgt)
                begin
                    data_next = ctl.data;
                end
            end
            CMD_ERASE:
            begin
                // the slot and everything above take the right neighbor
                if (pos >= ctl.tgt)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    assign rd_out   = (pos == ctl.sel) ? data_reg : '0;

endmodule

FILE: design/indexed_insert_delete_array.sv
// Ordered list of up to CAPACITY signed words held in a row of cells, one
// word per cell, with an element count. Each item carries one operation
// (append, drop last, insert, erase, overwrite, read, read last, clear)
// and returns exactly one result: read data, the count after the operation,
// an empty flag and a status. Insert and erase move every affected element
// at once, each cell taking its left or right neighbor, so the list is
// updated at the edge where the item is accepted. Read data comes back
// through a two-level or tree: each cell drives its word when selected,
// groups of 16 cells are or-ed into a register, and the group registers
// are or-ed into the output register. An accepted item's result passes
// from the cell row through the single stage register and then into the
// output register. The block takes no new item while the last one still
// sits in that stage, and the stage empties only when the output register
// is free or its result is being taken. A new item is accepted while a
// finished result still waits at the output. Entries above the count are
// never cleared; only positions below the count can be read.
module indexed_insert_delete_array
    import iida_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [7:0]  index,
    input  logic signed [31:0] value,

    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] read_value,
    output logic [8:0]  count,
    output logic        is_empty,
    output logic [1:0]  status
);

`include "indexed_insert_delete_array_macros.svh"

    // element count and the stage after the cell row
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               s1_valid_reg;
    logic                               s1_rd_en_reg;
    logic [1:0]                         s1_status_reg;
    logic [CNT_W-1:0]                   s1_count_reg;
    logic [NGRP-1:0][DATA_WIDTH-1:0]    s1_grp_reg;

    // output register
    logic                               out_valid_reg;
    logic [31:0]                        out_value_reg;
    logic [CNT_W-1:0]                   out_count_reg;
    logic                               out_empty_reg;
    logic [1:0]                         out_status_reg;

    logic                               in_fire;
    logic                               s1_go;

    // decode of the incoming item
    logic [CMP_W-1:0]                   idx_ext;
    logic [CMP_W-1:0]                   cnt_ext;
    logic                               is_full;
    logic                               no_elems;
    logic [1:0]                         dec_status;
    logic                               dec_rd_en;
    cmd_t                               dec_cmd;
    logic [IDX_W-1:0]                   dec_tgt;
    logic [IDX_W-1:0]                   dec_sel;
    logic [CNT_W-1:0]                   cnt_last;
    cell_ctl_t                          ctl;

    // cell row
    logic [DATA_WIDTH-1:0]              cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0]              cell_rd   [NGRP*GRP_SIZE];
    logic [NGRP-1:0][DATA_WIDTH-1:0]    grp_or;
    logic [DATA_WIDTH-1:0]              final_or;

    assign in_ready = !s1_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);

    assign idx_ext  = CMP_W'(index);
    assign cnt_ext  = CMP_W'(count_reg);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign no_elems = (count_reg == '0);
    assign cnt_last = count_reg - CNT_W'(1);

    always_comb
    begin
        dec_status = ST_OK;
        dec_rd_en  = 1'b0;
        dec_cmd    = CMD_HOLD;
        dec_tgt    = IDX_W'(idx_ext);
        dec_sel    = IDX_W'(idx_ext);
        count_next = count_reg;
        unique case (func_t'(func))
            FN_APPEND:
            begin
                if (is_full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_cmd    = CMD_LOAD;
                    dec_tgt    = IDX_W'(count_reg);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FN_DROP_LAST:
            begin
                if (no_elems)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    count_next = cnt_last;
                end
            end
            FN_INSERT:
            begin
                // full wins over a bad index
                if (is_full)
                begin
                    dec_status = ST_FULL;
                end
                else if (idx_ext > cnt_ext)
                begin
                    dec_status = ST_BAD_INDEX;
                end
                else
                begin
                    dec_cmd    = CMD_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FN_ERASE:
            begin
                if (no_elems)
                begin
                    dec_status = ST_EMPTY;
                end
                else if (idx_ext >= cnt_ext)
                begin
                    dec_status = ST_BAD_INDEX;
                end
                else
                begin
                    dec_cmd    = CMD_ERASE;
                    count_next = cnt_last;
                end
            end
            FN_OVERWRITE:
            begin
                if (no_elems)
                begin
                    dec_status = ST_EMPTY;
                end
                else if (idx_ext >= cnt_ext)
                begin
                    dec_status = ST_BAD_INDEX;
                end
                else
                begin
                    dec_cmd = CMD_LOAD;
                end
            end
            FN_READ:
            begin
                if (no_elems)
                begin
                    dec_status = ST_EMPTY;
                end
                else if (idx_ext >= cnt_ext)
                begin
                    dec_status = ST_BAD_INDEX;
                end
                else
                begin
                    dec_rd_en = 1'b1;
                end
            end
            FN_READ_LAST:
            begin
                if (no_elems)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_rd_en = 1'b1;
                    dec_sel   = IDX_W'(cnt_last);
                end
            end
            FN_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // cells only move on an accepted item
    always_comb
    begin
        ctl.cmd  = in_fire ? dec_cmd : CMD_HOLD;
        ctl.tgt  = dec_tgt;
        ctl.sel  = dec_sel;
        ctl.data = to_elem(value);
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_d;
            logic [DATA_WIDTH-1:0] right_d;

            if (gi == 0)
            begin : g_first
                assign left_d = ctl.data;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end

            iida_cell u_cell (
                .clk        (clk),
                .pos        (IDX_W'(gi)),
                .ctl        (ctl),
                .left_data  (left_d),
                .right_data (right_d),
                .data_out   (cell_data[gi]),
                .rd_out     (cell_rd[gi])
            );
        end

        // pad the last group with zero words
        for (gi = CAPACITY; gi < NGRP*GRP_SIZE; gi++)
        begin : g_pad
            assign cell_rd[gi] = '0;
        end
    endgenerate

    // first level of the read tree
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_or[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++)
            begin
                grp_or[g] = grp_or[g] | cell_rd[g*GRP_SIZE + k];
            end
        end
    end

    // second level of the read tree
    always_comb
    begin
        final_or = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            final_or = final_or | s1_grp_reg[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg <= count_next;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_rd_en_reg  <= dec_rd_en;
            s1_status_reg <= dec_status;
            s1_count_reg  <= count_next;
            s1_grp_reg    <= grp_or;
        end
        if (s1_go)
        begin
            out_value_reg  <= s1_rd_en_reg ? from_elem(final_or) : 32'd0;
            out_count_reg  <= s1_count_reg;
            out_empty_reg  <= (s1_count_reg == '0);
            out_status_reg <= s1_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = signed'(out_value_reg);
    assign count      = 9'(out_count_reg);
    assign is_empty   = out_empty_reg;
    assign status     = out_status_reg;

    // count stays within the capacity
    `IIDA_ASSERT_NOW(a_count_cap, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    // an accepted item always occupies the stage after the cells
    `IIDA_ASSERT_NEXT(a_s1_fill, clk, rst_n, in_fire, s1_valid_reg)
    // a failed operation returns no read data
    `IIDA_ASSERT_NOW(a_err_no_data, clk, rst_n, out_valid_reg && (out_status_reg != ST_OK),
                     out_value_reg == 32'd0)
    // empty flag agrees with the reported count
    `IIDA_ASSERT_NOW(a_empty_flag, clk, rst_n, out_valid_reg,
                     out_empty_reg == (out_count_reg == '0))

endmodule

FILE: verif/tb_indexed_insert_delete_array.sv
`timescale 1ns / 1ps

module tb_indexed_insert_delete_array;
    import iida_pkg::*;

    // no item moving on either channel for this many cycles means a hang
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    // one result as the list should report it
    typedef struct {
        logic signed [31:0] rd;
        logic [8:0]         cnt;
        logic               empty;
        logic [1:0]         st;
    } list_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         func;
    logic [7:0]         index;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] read_value;
    logic [8:0]         count;
    logic               is_empty;
    logic [1:0]         status;

    // shadow copy of the list, updated as each item is accepted
    logic signed [DATA_WIDTH-1:0] shadow_list [0:CAPACITY-1];
    int                           shadow_len;

    // results still owed by the block, oldest first
    list_result_t owed_results [$];

    // idling percentages for the current phase
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // bookkeeping
    int mismatches;
    int items_sent;
    int results_checked;
    int peak_len;
    int status_hits [4];
    int quiet_cycles;

    indexed_insert_delete_array DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .count      (count),
        .is_empty   (is_empty),
        .status     (status)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // apply one operation to the shadow list and return the result it must give
    function automatic list_result_t apply_list_op(input func_t op, input logic [7:0] idx,
                                                   input logic signed [31:0] val);
        list_result_t                 res;
        logic signed [63:0]           wide;
        logic signed [DATA_WIDTH-1:0] elem;
        res.rd = '0;
        res.st = ST_OK;
        wide = val;
        elem = wide[DATA_WIDTH-1:0];
        case (op)
            FN_APPEND:
            begin
                if (shadow_len >= CAPACITY)
                    res.st = ST_FULL;
                else
                begin
                    shadow_list[shadow_len] = elem;
                    shadow_len++;
                end
            end
            FN_DROP_LAST:
            begin
                if (shadow_len == 0)
                    res.st = ST_EMPTY;
                else
                    shadow_len--;
            end
            FN_INSERT:
            begin
                // full takes priority over a bad index
                if (shadow_len >= CAPACITY)
                    res.st = ST_FULL;
                else if (int'(idx) > shadow_len)
                    res.st = ST_BAD_INDEX;
                else
                begin
                    for (int i = shadow_len; i > int'(idx); i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[idx] = elem;
                    shadow_len++;
                end
            end
            FN_ERASE:
            begin
                if (shadow_len == 0)
                    res.st = ST_EMPTY;
                else if (int'(idx) >= shadow_len)
                    res.st = ST_BAD_INDEX;
                else
                begin
                    for (int i = int'(idx); i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            end
            FN_OVERWRITE:
            begin
                if (shadow_len == 0)
                    res.st = ST_EMPTY;
                else if (int'(idx) >= shadow_len)
                    res.st = ST_BAD_INDEX;
                else
                    shadow_list[idx] = elem;
            end
            FN_READ:
            begin
                if (shadow_len == 0)
                    res.st = ST_EMPTY;
                else if (int'(idx) >= shadow_len)
                    res.st = ST_BAD_INDEX;
                else
                begin
                    wide = shadow_list[idx];
                    res.rd = wide[31:0];
                end
            end
            FN_READ_LAST:
            begin
                if (shadow_len == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    wide = shadow_list[shadow_len-1];
                    res.rd = wide[31:0];
                end
            end
            default:
                shadow_len = 0;
        endcase
        res.cnt   = shadow_len[8:0];
        res.empty = (shadow_len == 0);
        return res;
    endfunction

    // drive one item, hold it until accepted, then log what it must produce
    // entered and left right after a rising edge; valid is only lowered for a gap
    task automatic send_item(input func_t op, input logic [7:0] idx,
                             input logic signed [31:0] val);
        int unsigned  gap;
        list_result_t res;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        index    <= idx;
        value    <= val;
        do
            @(posedge clk);
        while (!in_ready);
        res = apply_list_op(op, idx, val);
        owed_results = {owed_results, res};
        items_sent++;
        status_hits[res.st]++;
        if (shadow_len > peak_len)
            peak_len = shadow_len;
    endtask

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(15) != 0)
            return $urandom();
        case ($urandom_range(3))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            default: return -32'sd1;
        endcase
    endfunction

    // mostly in-range traffic with growth bias, one item in ten has a wild index
    task automatic send_random_item();
        int unsigned pick;
        func_t       op;
        logic [7:0]  idx;
        pick = $urandom_range(99);
        if (pick < 25)
            op = FN_APPEND;
        else if (pick < 35)
            op = FN_DROP_LAST;
        else if (pick < 55)
            op = FN_INSERT;
        else if (pick < 65)
            op = FN_ERASE;
        else if (pick < 75)
            op = FN_OVERWRITE;
        else if (pick < 87)
            op = FN_READ;
        else if (pick < 98)
            op = FN_READ_LAST;
        else
            op = FN_CLEAR;
        if ($urandom_range(9) == 0)
            idx = 8'($urandom_range(255));
        else if (op == FN_INSERT)
            idx = 8'($urandom_range((shadow_len > 255) ? 255 : shadow_len));
        else if (shadow_len > 0)
            idx = 8'($urandom_range(shadow_len - 1));
        else
            idx = 8'($urandom_range(255));
        send_item(op, idx, pick_value());
    endtask

    // every operation that needs an element, on an empty list, then a clear and a bad insert
    task automatic test_empty_list();
        send_item(FN_DROP_LAST, 8'd0, 32'sd0);
        send_item(FN_ERASE, 8'd0, 32'sd0);
        send_item(FN_OVERWRITE, 8'd0, 32'sd5);
        send_item(FN_READ, 8'd0, 32'sd0);
        send_item(FN_READ_LAST, 8'd255, 32'sd0);
        send_item(FN_CLEAR, 8'd0, 32'sd0);
        // only index 0 is a legal insert point here
        send_item(FN_INSERT, 8'd1, 32'sd9);
    endtask

    // extreme values, insert at both ends and middle, shifts and bad indexes
    task automatic test_edge_values_and_shifts();
        send_item(FN_INSERT, 8'd0, 32'sh8000_0000);
        send_item(FN_APPEND, 8'd0, 32'sh7FFF_FFFF);
        send_item(FN_APPEND, 8'd0, 32'sd0);
        send_item(FN_APPEND, 8'd0, -32'sd1);
        send_item(FN_INSERT, 8'd4, 32'sh5555_5555);
        send_item(FN_INSERT, 8'd2, 32'shAAAA_AAAA);
        send_item(FN_INSERT, 8'd7, 32'sd1);
        send_item(FN_READ, 8'd0, 32'sd0);
        send_item(FN_READ, 8'd2, 32'sd0);
        send_item(FN_READ, 8'd6, 32'sd0);
        send_item(FN_READ, 8'd255, 32'sd0);
        send_item(FN_READ_LAST, 8'd0, 32'sd0);
        send_item(FN_OVERWRITE, 8'd5, 32'sh1234_5678);
        send_item(FN_OVERWRITE, 8'd6, 32'sd7);
        send_item(FN_ERASE, 8'd2, 32'sd0);
        send_item(FN_ERASE, 8'd5, 32'sd0);
        send_item(FN_ERASE, 8'd0, 32'sd0);
        send_item(FN_DROP_LAST, 8'd0, 32'sd0);
        send_item(FN_READ_LAST, 8'd0, 32'sd0);
        send_item(FN_CLEAR, 8'd0, 32'sd0);
    endtask

    // grow the list to capacity, then hit the full and last-slot cases
    task automatic test_fill_to_capacity();
        while (shadow_len < CAPACITY)
        begin
            if ($urandom_range(9) < 7)
                send_item(FN_APPEND, 8'd0, pick_value());
            else
                send_item(FN_INSERT, 8'($urandom_range(shadow_len)), pick_value());
        end
        send_item(FN_APPEND, 8'd0, 32'sd1);
        send_item(FN_INSERT, 8'd0, 32'sd2);
        send_item(FN_INSERT, 8'd255, 32'sd3);
        send_item(FN_READ, 8'd255, 32'sd0);
        send_item(FN_READ_LAST, 8'd0, 32'sd0);
        send_item(FN_OVERWRITE, 8'd255, 32'sh8000_0000);
        send_item(FN_ERASE, 8'd255, 32'sd0);
        // insert at the end point with the top index
        send_item(FN_INSERT, 8'd255, 32'sh7FFF_FFFF);
        send_item(FN_ERASE, 8'd0, 32'sd0);
        send_item(FN_READ, 8'd0, 32'sd0);
        send_item(FN_DROP_LAST, 8'd0, 32'sd0);
        repeat (40) send_random_item();
        send_item(FN_CLEAR, 8'd0, 32'sd0);
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int num_items);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (num_items) send_random_item();
    endtask

    // result side: random stalls, compare each result with the oldest owed one
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result rd=%h cnt=%0d empty=%0b st=%0d",
                             $realtime, read_value, count, is_empty, status);
            end
            else
            begin
                want = owed_results.pop_front();
                results_checked++;
                if (read_value !== want.rd || count !== want.cnt ||
                    is_empty !== want.empty || status !== want.st)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: result %0d exp rd=%h cnt=%0d empty=%0b st=%0d",
                                 $realtime, results_checked, want.rd, want.cnt, want.empty,
                                 want.st);
                        $display("    got rd=%h cnt=%0d empty=%0b st=%0d",
                                 read_value, count, is_empty, status);
                    end
                end
            end
        end
    end

    // hang detection: no item moving on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results owed",
                     WATCHDOG_LIMIT, owed_results.size());
            $display("tb_indexed_insert_delete_array NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        func            = FN_APPEND;
        index           = '0;
        value           = '0;
        out_ready       = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        shadow_len      = 0;
        mismatches      = 0;
        items_sent      = 0;
        results_checked = 0;
        peak_len        = 0;
        quiet_cycles    = 0;
        foreach (status_hits[i])
            status_hits[i] = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at full speed
        test_empty_list();
        test_edge_values_and_shifts();

        // fill with light idling on both sides
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        test_fill_to_capacity();

        // random traffic through each idling pattern
        test_random_traffic(0, 0, 310);
        test_random_traffic(87, 0, 310);
        test_random_traffic(0, 87, 310);
        test_random_traffic(25, 25, 310);

        // drain outstanding results, then keep running to catch strays
        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("ran %0d items (%0d results checked), list peaked at %0d of %0d entries",
                 items_sent, results_checked, peak_len, CAPACITY);
        $display("status mix: ok %0d, full %0d, bad index %0d, empty %0d",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_BAD_INDEX],
                 status_hits[ST_EMPTY]);
        if (mismatches == 0)
            $display("tb_indexed_insert_delete_array OK");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("tb_indexed_insert_delete_array NOT OK");
        end
        $finish;
    end

endmodule
